FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Types, microcode encoding and control store of the fraction adder.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

   localparam int PC_W = 4;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_AD,
      OP_MUL_CB,
      OP_MUL_BD,
      OP_SPLIT,
      OP_HALVE_BOTH,
      OP_HALVE_U,
      OP_HALVE_V,
      OP_SUB,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SAVE_NUM,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ITEM,
      C_BOTH_EVEN,
      C_U_EVEN,
      C_V_EVEN,
      C_U_NE_V,
      C_DIV_MORE,
      C_SLOT_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } ctrl_type;

   typedef struct packed {
      logic item;
      logic both_even;
      logic u_even;
      logic v_even;
      logic u_ne_v;
      logic div_more;
      logic slot_busy;
   } flags_type;

   localparam logic [PC_W-1:0] S_IDLE       = 4'd0;
   localparam logic [PC_W-1:0] S_MUL_AD     = 4'd1;
   localparam logic [PC_W-1:0] S_MUL_CB     = 4'd2;
   localparam logic [PC_W-1:0] S_MUL_BD     = 4'd3;
   localparam logic [PC_W-1:0] S_SPLIT      = 4'd4;
   localparam logic [PC_W-1:0] S_HALVE_BOTH = 4'd5;
   localparam logic [PC_W-1:0] S_HALVE_U    = 4'd6;
   localparam logic [PC_W-1:0] S_HALVE_V    = 4'd7;
   localparam logic [PC_W-1:0] S_SUB        = 4'd8;
   localparam logic [PC_W-1:0] S_DIV_INIT   = 4'd9;
   localparam logic [PC_W-1:0] S_DIV_NUM    = 4'd10;
   localparam logic [PC_W-1:0] S_SAVE_NUM   = 4'd11;
   localparam logic [PC_W-1:0] S_DIV_DEN    = 4'd12;
   localparam logic [PC_W-1:0] S_EMIT       = 4'd13;
   localparam logic [PC_W-1:0] S_RETURN     = 4'd14;

   // control store: branch taken when cond holds before the step executes
   function automatic ctrl_type ucode_word(input logic [PC_W-1:0] pc);
      ctrl_type w;
      unique case (pc)
         S_IDLE:       w = '{OP_LOAD,       C_NO_ITEM,   S_IDLE};
         S_MUL_AD:     w = '{OP_MUL_AD,     C_NEVER,     S_IDLE};
         S_MUL_CB:     w = '{OP_MUL_CB,     C_NEVER,     S_IDLE};
         S_MUL_BD:     w = '{OP_MUL_BD,     C_NEVER,     S_IDLE};
         S_SPLIT:      w = '{OP_SPLIT,      C_NEVER,     S_IDLE};
         S_HALVE_BOTH: w = '{OP_HALVE_BOTH, C_BOTH_EVEN, S_HALVE_BOTH};
         S_HALVE_U:    w = '{OP_HALVE_U,    C_U_EVEN,    S_HALVE_U};
         S_HALVE_V:    w = '{OP_HALVE_V,    C_V_EVEN,    S_HALVE_V};
         S_SUB:        w = '{OP_SUB,        C_U_NE_V,    S_HALVE_V};
         S_DIV_INIT:   w = '{OP_DIV_INIT,   C_NEVER,     S_IDLE};
         S_DIV_NUM:    w = '{OP_DIV_STEP,   C_DIV_MORE,  S_DIV_NUM};
         S_SAVE_NUM:   w = '{OP_SAVE_NUM,   C_NEVER,     S_IDLE};
         S_DIV_DEN:    w = '{OP_DIV_STEP,   C_DIV_MORE,  S_DIV_DEN};
         S_EMIT:       w = '{OP_EMIT,       C_SLOT_BUSY, S_EMIT};
         S_RETURN:     w = '{OP_NOP,        C_ALWAYS,    S_IDLE};
         default:      w = '{OP_NOP,        C_ALWAYS,    S_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/fra_sequencer.sv
// ----------------------------------------------------------------------------
// fra_sequencer
// Step counter and branch unit walking the microcode control store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fra_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fra_pkg::flags_type flags,
   output fra_pkg::op_type        op
);

   logic [fra_pkg::PC_W-1:0] pc_ff;
   logic [fra_pkg::PC_W-1:0] pc_in;
   fra_pkg::ctrl_type        word;
   logic                     take;

   assign word = fra_pkg::ucode_word(pc_ff);
   assign op   = word.op;

   always_comb begin
      case (word.cond)
         fra_pkg::C_NEVER:     take = 1'b0;
         fra_pkg::C_ALWAYS:    take = 1'b1;
         fra_pkg::C_NO_ITEM:   take = !flags.item;
         fra_pkg::C_BOTH_EVEN: take = flags.both_even;
         fra_pkg::C_U_EVEN:    take = flags.u_even;
         fra_pkg::C_V_EVEN:    take = flags.v_even;
         fra_pkg::C_U_NE_V:    take = flags.u_ne_v;
         fra_pkg::C_DIV_MORE:  take = flags.div_more;
         fra_pkg::C_SLOT_BUSY: take = flags.slot_busy;
         default:              take = 1'b1;
      endcase
   end

   always_comb begin
      pc_in = take ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fra_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `ASSERT_NEXT(a_item_starts, clock, reset, flags.item, pc_ff == fra_pkg::S_MUL_AD, "item did not start the program")
   `ASSERT_IMPL(a_item_only_idle, clock, reset, flags.item, pc_ff == fra_pkg::S_IDLE, "item taken while busy")

endmodule

`default_nettype wire

FILE: rtl/fra_datapath.sv
// ----------------------------------------------------------------------------
// fra_datapath
// Multiplier, binary gcd registers, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fra_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fra_pkg::op_type    op,
   output fra_pkg::flags_type      flags,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_first_numerator,
   input  wire logic signed [15:0] req_first_denominator,
   input  wire logic signed [15:0] req_second_numerator,
   input  wire logic signed [15:0] req_second_denominator,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [32:0]      rsp_sum_numerator,
   output logic [30:0]             rsp_sum_denominator
);

   logic signed [15:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [15:0] a_in, b_in, c_in, d_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [32:0] num_ff, num_in;
   logic [31:0]        nmag_ff, nmag_in;
   logic [30:0]        dmag_ff, dmag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        u_ff, u_in, v_ff, v_in;
   logic [4:0]         k_ff, k_in;
   logic [30:0]        g_ff, g_in;
   logic [31:0]        dvd_ff, dvd_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        qnum_ff, qnum_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [32:0] out_num_ff, out_num_in;
   logic [30:0]        out_den_ff, out_den_in;
   logic               out_valid_ff, out_valid_in;

   logic               accept;
   logic               slot_free;
   logic signed [15:0] mul_x, mul_y;
   logic signed [31:0] mul_p;
   logic [31:0]        nabs;
   logic [30:0]        dabs;
   logic [31:0]        diff;
   logic [30:0]        u_shift;
   logic [31:0]        r2;
   logic               ge;
   logic signed [32:0] qext;

   assign req_stall = reset || (op != fra_pkg::OP_LOAD);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      case (op)
         fra_pkg::OP_MUL_AD: begin
            mul_x = a_ff;
            mul_y = d_ff;
         end
         fra_pkg::OP_MUL_CB: begin
            mul_x = c_ff;
            mul_y = b_ff;
         end
         default: begin
            mul_x = b_ff;
            mul_y = d_ff;
         end
      endcase
   end

   assign mul_p   = 32'(mul_x) * 32'(mul_y);
   assign nabs    = num_ff[32] ? 32'(-num_ff) : 32'(num_ff);
   assign dabs    = prod_ff[31] ? 31'(-prod_ff) : 31'(prod_ff);
   assign diff    = (u_ff > v_ff) ? u_ff - v_ff : v_ff - u_ff;
   assign u_shift = 31'(u_ff << k_ff);
   assign r2      = {rem_ff[30:0], dvd_ff[31]};
   assign ge      = r2 >= {1'b0, g_ff};
   assign qext    = signed'({1'b0, qnum_ff});

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      neg_in       = neg_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      qnum_in      = qnum_ff;
      cnt_in       = cnt_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      unique case (op)
         fra_pkg::OP_NOP: begin
         end
         fra_pkg::OP_LOAD: begin
            if (accept) begin
               a_in = req_first_numerator;
               b_in = (req_first_denominator == '0) ? 16'sd1 : req_first_denominator;
               c_in = req_second_numerator;
               d_in = (req_second_denominator == '0) ? 16'sd1 : req_second_denominator;
            end
         end
         fra_pkg::OP_MUL_AD: begin
            prod_in = mul_p;
         end
         fra_pkg::OP_MUL_CB: begin
            num_in  = 33'(prod_ff);
            prod_in = mul_p;
         end
         fra_pkg::OP_MUL_BD: begin
            num_in  = num_ff + 33'(prod_ff);
            prod_in = mul_p;
         end
         fra_pkg::OP_SPLIT: begin
            nmag_in = nabs;
            dmag_in = dabs;
            neg_in  = num_ff[32] ^ prod_ff[31];
            // gcd(0, x) = x: seed u with the denominator
            u_in    = (nabs == '0) ? {1'b0, dabs} : nabs;
            v_in    = {1'b0, dabs};
            k_in    = '0;
         end
         fra_pkg::OP_HALVE_BOTH: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 5'd1;
            end
         end
         fra_pkg::OP_HALVE_U: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end
         end
         fra_pkg::OP_HALVE_V: begin
            if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end
         end
         fra_pkg::OP_SUB: begin
            // both odd: difference is even, halve it at once
            if (u_ff > v_ff) begin
               u_in = v_ff;
            end
            v_in = {1'b0, diff[31:1]};
         end
         fra_pkg::OP_DIV_INIT: begin
            g_in   = u_shift;
            dvd_in = nmag_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         fra_pkg::OP_DIV_STEP: begin
            rem_in = ge ? r2 - {1'b0, g_ff} : r2;
            dvd_in = {dvd_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
         end
         fra_pkg::OP_SAVE_NUM: begin
            qnum_in = dvd_ff;
            dvd_in  = {1'b0, dmag_ff};
            rem_in  = '0;
            cnt_in  = '0;
         end
         fra_pkg::OP_EMIT: begin
            if (slot_free) begin
               out_num_in   = neg_ff ? -qext : qext;
               out_den_in   = dvd_ff[30:0];
               out_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      nmag_ff    <= nmag_in;
      dmag_ff    <= dmag_in;
      neg_ff     <= neg_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      qnum_ff    <= qnum_in;
      cnt_ff     <= cnt_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign flags.item      = accept;
   assign flags.both_even = !u_ff[0] && !v_ff[0];
   assign flags.u_even    = !u_ff[0];
   assign flags.v_even    = !v_ff[0];
   assign flags.u_ne_v    = (u_ff != v_ff);
   assign flags.div_more  = (cnt_ff != '1);
   assign flags.slot_busy = !slot_free;

   assign rsp_valid           = out_valid_ff;
   assign rsp_sum_numerator   = out_num_ff;
   assign rsp_sum_denominator = out_den_ff;

   `ASSERT_IMPL(a_v_nonzero, clock, reset, op == fra_pkg::OP_HALVE_V, v_ff != '0, "gcd operand v is zero")
   `ASSERT_IMPL(a_div_nonzero, clock, reset, op == fra_pkg::OP_DIV_STEP, g_ff != '0, "divide by zero")
   `ASSERT_IMPL(a_div_exact, clock, reset, op == fra_pkg::OP_SAVE_NUM || op == fra_pkg::OP_EMIT, rem_ff == '0, "division left a remainder")
   `ASSERT_IMPL(a_den_positive, clock, reset, out_valid_ff, out_den_ff != '0, "zero denominator on output")

endmodule

`default_nettype wire

FILE: rtl/fraction_add_reduce.sv
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two signed 16-bit fractions and returns the sum in lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: two fractions a/b and c/d. A zero denominator
//   is read as one. rsp_* returns (a*d + c*b)/(b*d) reduced by the gcd,
//   denominator positive, zero sum as 0/1.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low. req_stall is high during reset and while an item is in
//   progress. A microcoded sequencer drives one shared 16x16 multiplier,
//   a binary gcd loop and a one-bit-per-cycle restoring divider.
//   From acceptance to rsp_valid the block runs 3 multiply steps and a
//   split step, the binary gcd loop (halving runs, each closed by a step
//   that finds nothing to halve, and subtract steps), two 32-bit
//   divisions, the divider setup and save steps and the output step. It
//   then returns to idle and takes no new item before it is back there.
//   The result sits in an output register; a stalled receiver holds it and
//   the block waits at the output step until the register frees up.
//   Reset (synchronous) returns the sequencer to idle and empties the
//   output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_add_reduce (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_first_numerator,
   input  wire logic signed [15:0] req_first_denominator,
   input  wire logic signed [15:0] req_second_numerator,
   input  wire logic signed [15:0] req_second_denominator,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [32:0]      rsp_sum_numerator,
   output logic [30:0]             rsp_sum_denominator
);

   fra_pkg::op_type    op;
   fra_pkg::flags_type flags;

   fra_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   fra_datapath u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .op                     (op),
      .flags                  (flags),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_first_numerator    (req_first_numerator),
      .req_first_denominator  (req_first_denominator),
      .req_second_numerator   (req_second_numerator),
      .req_second_denominator (req_second_denominator),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_sum_numerator      (rsp_sum_numerator),
      .rsp_sum_denominator    (rsp_sum_denominator)
   );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_reduce testbench
// Sends pairs of signed 16-bit fractions and checks each reduced sum against
// a predictor inside the bench. Directed corners come first: full-scale
// values, zero denominators, negative denominators, zero sums. Random pairs
// follow, some with shared power-of-two factors to drive the gcd loop deep,
// and a back-to-back stretch. Sender bursts and receiver stalls vary.
// ----------------------------------------------------------------------------

module testbench;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] d;
      logic signed [32:0] num;
      logic [30:0]        den;
   } reduced_sum_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_first_numerator = '0;
   logic signed [15:0] req_first_denominator = '0;
   logic signed [15:0] req_second_numerator = '0;
   logic signed [15:0] req_second_denominator = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [32:0] rsp_sum_numerator;
   logic [30:0]        rsp_sum_denominator;

   reduced_sum_type pending_sums[$];
   int              mismatch_count = 0;
   int              burst_left = 0;
   int              max_gap = 12;
   int              stall_pct = 40;
   int              hold_left = 0;

   fraction_add_reduce DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_first_numerator    (req_first_numerator),
      .req_first_denominator  (req_first_denominator),
      .req_second_numerator   (req_second_numerator),
      .req_second_denominator (req_second_denominator),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_sum_numerator      (rsp_sum_numerator),
      .rsp_sum_denominator    (rsp_sum_denominator)
   );

   always #10 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 40)
         $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // a/b + c/d in lowest terms, zero denominators read as one
   function automatic reduced_sum_type predict_reduced_sum(
      input logic signed [15:0] a, b, c, d);
      reduced_sum_type s;
      longint          sa, sb, sc, sd, n, m, x, y, r;
      sa = a;
      sb = b;
      sc = c;
      sd = d;
      if (sb == 0) sb = 1;
      if (sd == 0) sd = 1;
      n = sa * sd + sc * sb;
      m = sb * sd;
      x = (n < 0) ? -n : n;
      y = (m < 0) ? -m : m;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      n = n / x;
      m = m / x;
      if (m < 0) begin
         n = -n;
         m = -m;
      end
      s.a = a;
      s.b = b;
      s.c = c;
      s.d = d;
      s.num = n[32:0];
      s.den = m[30:0];
      return s;
   endfunction

   task automatic send_pair(input logic signed [15:0] a, b, c, d);
      int gap;
      if (burst_left == 0) begin
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_first_numerator <= a;
      req_first_denominator <= b;
      req_second_numerator <= c;
      req_second_denominator <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_sums.push_back(predict_reduced_sum(a, b, c, d));
      burst_left--;
   endtask

   function automatic logic signed [15:0] pick_field();
      logic signed [15:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 16'sh8000;
               1: v = 16'sh7fff;
               2: v = 16'sh0000;
               3: v = 16'sh0001;
               default: v = 16'shffff;
            endcase
         end
         1: v = 16'($urandom_range(0, 16)) - 16'sd8;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // value from 0 to 255 times a power of two, random sign
   function automatic logic signed [15:0] pick_factored();
      logic signed [15:0] v;
      v = 16'($urandom_range(0, 255) << $urandom_range(0, 8));
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic test_corners;
      send_pair(16'sd0, 16'sd1, 16'sd0, 16'sd1);
      send_pair(16'sd1, 16'sd0, 16'sd1, 16'sd0);
      send_pair(16'sd3, 16'sd0, -16'sd3, 16'sd0);
      send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_pair(16'sd1, 16'sd2, -16'sd1, 16'sd2);
      send_pair(16'sd1, -16'sd2, 16'sd1, -16'sd2);
      send_pair(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
      send_pair(16'sd1, 16'sd3, 16'sd1, 16'sd6);
      send_pair(16'sd12, -16'sd18, -16'sd10, 16'sd15);
      send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_pair(16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
      send_pair(16'sh8000, -16'sd1, 16'sh8000, -16'sd1);
      send_pair(16'sh7fff, 16'sd1, 16'sh7fff, 16'sd1);
      send_pair(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_pair(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_pair(16'sd1, 16'sh7fff, 16'sd1, 16'sh8000);
      send_pair(16'sd5, 16'sh8000, -16'sd5, 16'sh7fff);
      send_pair(16'sh8000, 16'sd0, 16'sd0, 16'sh8000);
      send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_pair(-16'sd1, 16'sh7fff, 16'sd1, -16'sh7fff);
      send_pair(16'sh7fff, 16'sh8001, 16'sh8001, 16'sh7fff);
      send_pair(16'sh4000, 16'sh4000, 16'sh2000, 16'sh6000);
   endtask

   task automatic test_random_pairs(input int count);
      repeat (count)
         send_pair(pick_field(), pick_field(), pick_field(), pick_field());
   endtask

   task automatic test_shared_factors(input int count);
      repeat (count)
         send_pair(pick_factored(), pick_factored(), pick_factored(), pick_factored());
   endtask

   task automatic test_back_to_back(input int count);
      max_gap = 0;
      stall_pct = 0;
      test_random_pairs(count);
      max_gap = 12;
      stall_pct = 40;
   endtask

   // receiver: runs of stall and free cycles, now and then a long hold
   always @(posedge clock) begin : rsp_stall_gen
      logic stalling;
      if (hold_left == 0) begin
         stalling = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
         if (stalling)
            hold_left = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
         else
            hold_left = $urandom_range(1, 40);
         rsp_stall <= stalling;
      end
      hold_left--;
   end

   always @(posedge clock) begin : sum_checker
      reduced_sum_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            flag_mismatch($sformatf("unexpected sum %0d/%0d",
                                    rsp_sum_numerator, rsp_sum_denominator));
         end else begin
            want = pending_sums.pop_front();
            if (rsp_sum_numerator !== want.num)
               flag_mismatch($sformatf("%0d/%0d + %0d/%0d: numerator %0d, want %0d",
                                       want.a, want.b, want.c, want.d,
                                       rsp_sum_numerator, want.num));
            if (rsp_sum_denominator !== want.den)
               flag_mismatch($sformatf("%0d/%0d + %0d/%0d: denominator %0d, want %0d",
                                       want.a, want.b, want.c, want.d,
                                       rsp_sum_denominator, want.den));
         end
      end
   end

   initial begin
      #30_000_000;
      $display("fraction_add_reduce verification failed");
      $finish;
   end

   initial begin : run_tests
      int i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_corners();
      test_random_pairs(560);
      test_shared_factors(260);
      test_back_to_back(60);
      test_random_pairs(40);
      req_valid <= 1'b0;
      for (i = 0; i < 20000 && pending_sums.size() != 0; i++) @(posedge clock);
      if (pending_sums.size() != 0)
         flag_mismatch($sformatf("%0d sums never arrived", pending_sums.size()));
      repeat (200) @(posedge clock);
      if (mismatch_count == 0)
         $display("fraction_add_reduce verification clean");
      else
         $display("fraction_add_reduce verification failed");
      $finish;
   end

endmodule
